[rtl/nsrc_pkg.sv]
// Shared types and constants for the nearest-sample rate converter.
package nsrc_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LEVEL_W  = 8;
	localparam int unsigned STEP_W   = 12;
	localparam int unsigned COUNT_W  = 24;
	localparam int unsigned PHASE_W  = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [STEP_W-1:0]  STEP_MIN   = 12'd4;
	localparam logic [STEP_W-1:0]  STEP_RESET = 12'd256;
	localparam logic [PHASE_W-1:0] ONE_SAMPLE = 13'd256;
	localparam logic [7:0]         OFFSET8    = 8'd128;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

	typedef struct packed {
		logic accept;   // latch the incoming item
		logic emit;     // load one result and advance phase and count
		logic finish;   // item ends with no further result
	} cmd_t;

	typedef struct packed {
		logic can_emit; // phase within sample and outputs remaining
		logic last;     // the result about to be emitted ends this item
	} status_t;

endpackage

[rtl/nearest_sample_rate_converter.sv]
// Top level of the nearest-sample rate converter.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    sample_raw
//  out       source     out_valid / out_ready  sample_out, peak_level, run_last, sound_done
//  cfg       sink       cfg_we                 cfg_index, cfg_wdata
//
// An item is accepted in the idle state, then gives one result a cycle while the
// result register can take it, or ends in the run state with no result. The controller's
// run state and the single result register set this pace.
// Reset clears configuration to its defaults and the phase, count and peak to zero.
// A stalled result register holds the controller in its run state until taken.
module nearest_sample_rate_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [nsrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsrc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]        sample_raw,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] sample_out,
	output logic [nsrc_pkg::LEVEL_W-1:0]         peak_level,
	output logic                                 run_last,
	output logic                                 sound_done
);

	nsrc_pkg::cmd_t    cmd;
	nsrc_pkg::status_t status;

	nsrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	nsrc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_raw (sample_raw),
		.cmd        (cmd),
		.status     (status),
		.sample_out (sample_out),
		.peak_level (peak_level),
		.run_last   (run_last),
		.sound_done (sound_done)
	);

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready))
		else $error("result register overwritten while stalled");

	// an accepted item always enters the run state
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("input ready right after accepting an item");

	// the final result of a sound also ends its item
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sound_done) |-> run_last)
		else $error("sound finished without ending the item");

	// peak of |sample| >> 8 cannot pass 128
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (peak_level <= 8'd128))
		else $error("peak level out of range");

endmodule

[rtl/nsrc_datapath.sv]
// Datapath: configuration, phase accumulator, output counter, peak and result register.
module nsrc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nsrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nsrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [nsrc_pkg::SAMPLE_W-1:0]       sample_raw,
	input  nsrc_pkg::cmd_t                      cmd,
	output nsrc_pkg::status_t                   status,
	output logic signed [nsrc_pkg::SAMPLE_W-1:0] sample_out,
	output logic [nsrc_pkg::LEVEL_W-1:0]        peak_level,
	output logic                                run_last,
	output logic                                sound_done
);

	logic [nsrc_pkg::STEP_W-1:0]   step_q;
	logic                          mode_q;
	logic [nsrc_pkg::COUNT_W-1:0]  count_q;
	logic [nsrc_pkg::PHASE_W-1:0]  phase_q;
	logic [nsrc_pkg::COUNT_W-1:0]  emitted_q;
	logic [nsrc_pkg::LEVEL_W-1:0]  peak_q;
	logic [nsrc_pkg::SAMPLE_W-1:0] samp_q;
	logic [nsrc_pkg::LEVEL_W-1:0]  lvl_q;

	logic [nsrc_pkg::SAMPLE_W-1:0] samp_in;
	logic [nsrc_pkg::SAMPLE_W-1:0] mag_in;
	logic [nsrc_pkg::STEP_W-1:0]   step_eff;
	logic [nsrc_pkg::PHASE_W-1:0]  phase_next;
	logic [nsrc_pkg::COUNT_W-1:0]  emitted_next;
	logic [nsrc_pkg::LEVEL_W-1:0]  peak_next;
	logic                          next_past;

	// 8-bit mode: (b - 128) * 256 is the byte with its top bit flipped, then a zero byte
	assign samp_in = mode_q ? sample_raw
		: {sample_raw[7:0] ^ nsrc_pkg::OFFSET8, 8'h00};
	assign mag_in  = samp_in[nsrc_pkg::SAMPLE_W-1] ? (~samp_in + 16'd1) : samp_in;

	assign step_eff     = (step_q < nsrc_pkg::STEP_MIN) ? nsrc_pkg::STEP_MIN : step_q;
	assign phase_next   = phase_q + {1'b0, step_eff};
	assign emitted_next = emitted_q + 24'd1;
	assign peak_next    = (lvl_q > peak_q) ? lvl_q : peak_q;
	assign next_past    = (phase_next >= nsrc_pkg::ONE_SAMPLE);

	assign status.can_emit = (phase_q < nsrc_pkg::ONE_SAMPLE) && (emitted_q < count_q);
	assign status.last     = next_past || (emitted_next == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= nsrc_pkg::STEP_RESET;
			mode_q    <= 1'b1;
			count_q   <= '0;
			phase_q   <= '0;
			emitted_q <= '0;
			peak_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nsrc_pkg::REG_STEP:  step_q <= cfg_wdata[nsrc_pkg::STEP_W-1:0];
					nsrc_pkg::REG_MODE:  mode_q <= cfg_wdata[0];
					nsrc_pkg::REG_COUNT: begin
						count_q   <= cfg_wdata[nsrc_pkg::COUNT_W-1:0];
						phase_q   <= '0;
						emitted_q <= '0;
						peak_q    <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.emit) begin
				emitted_q <= emitted_next;
				peak_q    <= peak_next;
				// the wrap back into the next sample happens with the item's last result
				if (status.last && next_past)
					phase_q <= phase_next - nsrc_pkg::ONE_SAMPLE;
				else
					phase_q <= phase_next;
			end else if (cmd.finish) begin
				if (phase_q >= nsrc_pkg::ONE_SAMPLE)
					phase_q <= phase_q - nsrc_pkg::ONE_SAMPLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_q <= samp_in;
			lvl_q  <= mag_in[nsrc_pkg::SAMPLE_W-1 -: nsrc_pkg::LEVEL_W];
		end
		if (cmd.emit) begin
			sample_out <= samp_q;
			peak_level <= peak_next;
			run_last   <= status.last;
			sound_done <= (emitted_next == count_q);
		end
	end

endmodule

[rtl/nsrc_ctrl.sv]
// Controller: item sequencing and result valid flag.
module nsrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  nsrc_pkg::status_t status,
	output nsrc_pkg::cmd_t    cmd
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid || out_ready;

	assign cmd.accept = in_valid && in_ready;
	assign cmd.emit   = (state_q == S_RUN) && status.can_emit && slot_free;
	assign cmd.finish = (state_q == S_RUN) && !status.can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd.accept)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (cmd.finish || (cmd.emit && status.last))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
